/* rtl/stopword_filter_unit_macros.svh */
// Assertion macros of the stopword filter RTL, used by sfu_back
`ifndef STOPWORD_FILTER_UNIT_MACROS_SVH
`define STOPWORD_FILTER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SFU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("sfu check failed");
`define SFU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("sfu check failed");
`else
`define SFU_ASSERT(lbl, clk, rst_n, prop)
`define SFU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/sfu_pkg.sv */
// Shared types and constants of the stopword filter
`timescale 1ns / 1ps
package sfu_pkg;
  localparam int WORD_MAX_DEF   = 32;
  localparam int STOP_LEN_DEF   = 16;
  localparam int STOP_COUNT_DEF = 256;

  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_NEWLINE = 8'd10;

  localparam logic [1:0] ACT_TEXT   = 2'd0;
  localparam logic [1:0] ACT_LOAD   = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_LONG = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic KIND_TEXT   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    OP_TEXT,
    OP_LOAD,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
    logic       delim;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LREQ,
    S_LCHK,
    S_CREQ,
    S_CCHK,
    S_EMIT_SP,
    S_WREQ,
    S_WOUT,
    S_NL,
    S_STAT
  } state_t;
endpackage

/* rtl/sfu_ram.sv */
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module sfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

/* rtl/sfu_front.sv */
// Input side: accept items, classify them into commands for the queue
`timescale 1ns / 1ps
module sfu_front (
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [1:0]   in_action,
  input  logic [7:0]   in_byte_value,
  input  logic         q_full,
  output logic         q_push,
  output sfu_pkg::cmd_t q_data
);
  logic known;

  always_comb begin
    q_data.ch    = in_byte_value;
    q_data.delim = (in_byte_value == sfu_pkg::CH_SPACE) ||
                   (in_byte_value == sfu_pkg::CH_NEWLINE);
    known = 1'b1;
    unique case (in_action)
      sfu_pkg::ACT_TEXT:  q_data.op = sfu_pkg::OP_TEXT;
      sfu_pkg::ACT_LOAD:  q_data.op = sfu_pkg::OP_LOAD;
      sfu_pkg::ACT_CLEAR: q_data.op = sfu_pkg::OP_CLEAR;
      default: begin
        // unused action: accept and drop
        q_data.op = sfu_pkg::OP_TEXT;
        known     = 1'b0;
      end
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && known;
endmodule

/* rtl/sfu_queue.sv */
// Two-entry command queue between front and back
`timescale 1ns / 1ps
module sfu_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sfu_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output sfu_pkg::cmd_t q_data
);
  localparam logic [1:0] QDEPTH = 2'd2;

  sfu_pkg::cmd_t slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign full    = (cnt_r == QDEPTH);
  assign q_valid = (cnt_r != 2'd0);
  assign q_data  = slot_r[rp_r];
  assign do_pop  = pop && q_valid;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_data;
    end
  end
endmodule

/* rtl/sfu_back.sv */
// Back end: word buffer, stopword table, table walk and result emission
`timescale 1ns / 1ps
`include "stopword_filter_unit_macros.svh"
module sfu_back #(
  parameter int WORD_MAX   = sfu_pkg::WORD_MAX_DEF,
  parameter int STOP_LEN   = sfu_pkg::STOP_LEN_DEF,
  parameter int STOP_COUNT = sfu_pkg::STOP_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  sfu_pkg::cmd_t q_data,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_out_byte,
  output logic          out_kind,
  output logic [1:0]    out_status,
  output logic          out_truncated,
  output logic          out_last
);
  localparam int IW  = $clog2(WORD_MAX);
  localparam int LW  = $clog2(WORD_MAX + 1);
  localparam int SW  = $clog2(STOP_LEN);
  localparam int LLW = $clog2(STOP_LEN + 1);
  localparam int EW  = (STOP_COUNT > 1) ? $clog2(STOP_COUNT) : 1;
  localparam int CW  = $clog2(STOP_COUNT + 1);
  localparam int CD  = STOP_COUNT * STOP_LEN;
  localparam int CAW = $clog2(CD);

  sfu_pkg::state_t state_r, state_nxt;
  sfu_pkg::cmd_t   cmd_r, cmd_nxt;
  logic [IW-1:0]  idx_r, idx_nxt;
  logic [EW-1:0]  ent_r, ent_nxt;
  logic [LW-1:0]  word_len_r, word_len_nxt;
  logic           word_ovf_r, word_ovf_nxt;
  logic           line_start_r, line_start_nxt;
  logic [CW-1:0]  stop_count_r, stop_count_nxt;
  logic [LLW-1:0] load_len_r, load_len_nxt;
  logic           load_ovf_r, load_ovf_nxt;
  logic [1:0]     stat_r, stat_nxt;

  logic           out_valid_r;
  logic [7:0]     out_byte_r;
  logic           out_kind_r, out_tr_r, out_last_r;
  logic [1:0]     out_status_r;

  logic       emit, slot_free, is_nl, last_idx;
  logic [7:0] e_byte;
  logic       e_kind, e_tr, e_last;
  logic [1:0] e_status;

  logic          wb_we;
  logic [7:0]    wb_rd;
  logic          sc_we;
  logic [CAW-1:0] sc_waddr, sc_raddr;
  logic [7:0]    sc_rd;
  logic          sl_we;
  logic [LLW-1:0] sl_rd;

  sfu_ram #(.WIDTH(8), .DEPTH(WORD_MAX)) u_word (
    .clk(clk), .wr_en(wb_we), .wr_addr(IW'(word_len_r)), .wr_data(q_data.ch),
    .rd_addr(idx_r), .rd_data(wb_rd)
  );

  sfu_ram #(.WIDTH(8), .DEPTH(CD)) u_chars (
    .clk(clk), .wr_en(sc_we), .wr_addr(sc_waddr), .wr_data(q_data.ch),
    .rd_addr(sc_raddr), .rd_data(sc_rd)
  );

  sfu_ram #(.WIDTH(LLW), .DEPTH(STOP_COUNT)) u_lens (
    .clk(clk), .wr_en(sl_we), .wr_addr(EW'(stop_count_r)), .wr_data(load_len_r),
    .rd_addr(ent_r), .rd_data(sl_rd)
  );

  assign sc_waddr  = CAW'(stop_count_r) * CAW'(STOP_LEN) + CAW'(load_len_r);
  assign sc_raddr  = CAW'(ent_r) * CAW'(STOP_LEN) + CAW'(SW'(idx_r));
  assign slot_free = !out_valid_r || !out_stall;
  assign is_nl     = (cmd_r.ch == sfu_pkg::CH_NEWLINE);
  assign last_idx  = (idx_r == IW'(word_len_r - LW'(1)));
  assign q_pop     = q_valid && (state_r == sfu_pkg::S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    idx_nxt        = idx_r;
    ent_nxt        = ent_r;
    word_len_nxt   = word_len_r;
    word_ovf_nxt   = word_ovf_r;
    line_start_nxt = line_start_r;
    stop_count_nxt = stop_count_r;
    load_len_nxt   = load_len_r;
    load_ovf_nxt   = load_ovf_r;
    stat_nxt       = stat_r;
    wb_we    = 1'b0;
    sc_we    = 1'b0;
    sl_we    = 1'b0;
    emit     = 1'b0;
    e_byte   = 8'd0;
    e_kind   = sfu_pkg::KIND_TEXT;
    e_status = sfu_pkg::ST_OK;
    e_tr     = word_ovf_r;
    e_last   = 1'b0;
    unique case (state_r)
      sfu_pkg::S_IDLE: begin
        if (q_valid) begin
          cmd_nxt = q_data;
          unique case (q_data.op)
            sfu_pkg::OP_TEXT: begin
              if (!q_data.delim) begin
                if (word_len_r < LW'(WORD_MAX)) begin
                  wb_we        = 1'b1;
                  word_len_nxt = word_len_r + LW'(1);
                end else begin
                  word_ovf_nxt = 1'b1;
                end
              end else if (word_ovf_r || word_len_r == '0 || stop_count_r == '0) begin
                state_nxt = sfu_pkg::S_EMIT_SP;
              end else begin
                ent_nxt   = '0;
                state_nxt = sfu_pkg::S_LREQ;
              end
            end
            sfu_pkg::OP_LOAD: begin
              stat_nxt  = sfu_pkg::ST_OK;
              state_nxt = sfu_pkg::S_STAT;
              if (!q_data.delim) begin
                if (load_len_r < LLW'(STOP_LEN)) begin
                  sc_we        = (stop_count_r < CW'(STOP_COUNT));
                  load_len_nxt = load_len_r + LLW'(1);
                end else begin
                  load_ovf_nxt = 1'b1;
                end
              end else begin
                if (load_ovf_r) begin
                  stat_nxt = sfu_pkg::ST_LONG;
                end else if (load_len_r != '0) begin
                  if (stop_count_r >= CW'(STOP_COUNT)) begin
                    stat_nxt = sfu_pkg::ST_FULL;
                  end else begin
                    sl_we          = 1'b1;
                    stop_count_nxt = stop_count_r + CW'(1);
                  end
                end
                load_len_nxt = '0;
                load_ovf_nxt = 1'b0;
              end
            end
            default: begin
              stop_count_nxt = '0;
              load_len_nxt   = '0;
              load_ovf_nxt   = 1'b0;
              stat_nxt       = sfu_pkg::ST_OK;
              state_nxt      = sfu_pkg::S_STAT;
            end
          endcase
        end
      end
      sfu_pkg::S_LREQ: state_nxt = sfu_pkg::S_LCHK;
      sfu_pkg::S_LCHK: begin
        if (8'(sl_rd) == 8'(word_len_r)) begin
          idx_nxt   = '0;
          state_nxt = sfu_pkg::S_CREQ;
        end else if (CW'(ent_r) + CW'(1) == stop_count_r) begin
          state_nxt = sfu_pkg::S_EMIT_SP;
        end else begin
          ent_nxt   = ent_r + EW'(1);
          state_nxt = sfu_pkg::S_LREQ;
        end
      end
      sfu_pkg::S_CREQ: state_nxt = sfu_pkg::S_CCHK;
      sfu_pkg::S_CCHK: begin
        if (sc_rd != wb_rd) begin
          if (CW'(ent_r) + CW'(1) == stop_count_r) begin
            state_nxt = sfu_pkg::S_EMIT_SP;
          end else begin
            ent_nxt   = ent_r + EW'(1);
            state_nxt = sfu_pkg::S_LREQ;
          end
        end else if (last_idx) begin
          state_nxt = sfu_pkg::S_NL;
        end else begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = sfu_pkg::S_CREQ;
        end
      end
      sfu_pkg::S_EMIT_SP: begin
        if (line_start_r || slot_free) begin
          emit           = !line_start_r;
          e_byte         = sfu_pkg::CH_SPACE;
          e_last         = (word_len_r == '0) && !is_nl;
          line_start_nxt = 1'b0;
          idx_nxt        = '0;
          state_nxt      = (word_len_r != '0) ? sfu_pkg::S_WREQ : sfu_pkg::S_NL;
        end
      end
      sfu_pkg::S_WREQ: state_nxt = sfu_pkg::S_WOUT;
      sfu_pkg::S_WOUT: begin
        if (slot_free) begin
          emit   = 1'b1;
          e_byte = wb_rd;
          e_last = last_idx && !is_nl;
          if (last_idx) begin
            state_nxt = sfu_pkg::S_NL;
          end else begin
            idx_nxt   = idx_r + IW'(1);
            state_nxt = sfu_pkg::S_WREQ;
          end
        end
      end
      sfu_pkg::S_NL: begin
        if (!is_nl || slot_free) begin
          emit         = is_nl;
          e_byte       = sfu_pkg::CH_NEWLINE;
          e_last       = 1'b1;
          if (is_nl) begin
            line_start_nxt = 1'b1;
          end
          word_len_nxt = '0;
          word_ovf_nxt = 1'b0;
          state_nxt    = sfu_pkg::S_IDLE;
        end
      end
      sfu_pkg::S_STAT: begin
        if (slot_free) begin
          emit      = 1'b1;
          e_kind    = sfu_pkg::KIND_STATUS;
          e_status  = stat_r;
          e_tr      = 1'b0;
          e_last    = 1'b1;
          state_nxt = sfu_pkg::S_IDLE;
        end
      end
      default: state_nxt = sfu_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sfu_pkg::S_IDLE;
      word_len_r   <= '0;
      word_ovf_r   <= 1'b0;
      line_start_r <= 1'b1;
      stop_count_r <= '0;
      load_len_r   <= '0;
      load_ovf_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      word_len_r   <= word_len_nxt;
      word_ovf_r   <= word_ovf_nxt;
      line_start_r <= line_start_nxt;
      stop_count_r <= stop_count_nxt;
      load_len_r   <= load_len_nxt;
      load_ovf_r   <= load_ovf_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    idx_r  <= idx_nxt;
    ent_r  <= ent_nxt;
    stat_r <= stat_nxt;
    if (emit) begin
      out_byte_r   <= e_byte;
      out_kind_r   <= e_kind;
      out_status_r <= e_status;
      out_tr_r     <= e_tr;
      out_last_r   <= e_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_out_byte  = out_byte_r;
  assign out_kind      = out_kind_r;
  assign out_status    = out_status_r;
  assign out_truncated = out_tr_r;
  assign out_last      = out_last_r;

  `SFU_ASSERT(a_status_last, clk, rst_n, (out_valid_r && out_kind_r) |-> (out_last_r && out_byte_r == 8'd0 && !out_tr_r))
  `SFU_ASSERT(a_len_bound, clk, rst_n, word_len_r <= LW'(WORD_MAX))
  `SFU_ASSERT(a_count_bound, clk, rst_n, stop_count_r <= CW'(STOP_COUNT))
  `SFU_ASSERT(a_walk_nonempty, clk, rst_n, (state_r == sfu_pkg::S_LREQ) |-> (stop_count_r != '0 && word_len_r != '0))
  `SFU_ASSERT_NEXT(a_idle_pop, clk, rst_n, (state_r == sfu_pkg::S_IDLE && q_valid && q_data.op != sfu_pkg::OP_TEXT), state_r == sfu_pkg::S_STAT)
endmodule

/* rtl/stopword_filter_unit.sv */
// Top level of the streaming stopword filter
// A text byte inside a word gives no result; a load or clear item passes the queue, the
//   IDLE and STAT states and the output register before its status result is shown.
// Walk, set by the single read port of the table memories: a word end that is not empty
//   or overlong walks a non-empty table, each entry through LREQ and LCHK, each compared
//   byte of an equal-length entry through CREQ and CCHK, then each emitted byte through WREQ and WOUT.
// Reset: synchronous active-low rst_n empties the queue and the table and sets line start.
`timescale 1ns / 1ps
module stopword_filter_unit #(
  parameter int WORD_MAX   = sfu_pkg::WORD_MAX_DEF,
  parameter int STOP_LEN   = sfu_pkg::STOP_LEN_DEF,
  parameter int STOP_COUNT = sfu_pkg::STOP_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_action,
  input  logic [7:0] in_byte_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_out_byte,
  output logic       out_kind,
  output logic [1:0] out_status,
  output logic       out_truncated,
  output logic       out_last
);
  // front side: classify each item and push it; the unused action is dropped here
  logic          q_full, q_push, q_pop, q_valid;
  sfu_pkg::cmd_t push_cmd, head_cmd;

  sfu_front u_front (
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_byte_value(in_byte_value), .q_full(q_full), .q_push(q_push), .q_data(push_cmd)
  );

  // short queue lets the front keep taking items while the back walks the table
  sfu_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(push_cmd), .full(q_full),
    .pop(q_pop), .q_valid(q_valid), .q_data(head_cmd)
  );

  // back side: word buffer, table, match walk and the output register
  sfu_back #(
    .WORD_MAX(WORD_MAX), .STOP_LEN(STOP_LEN), .STOP_COUNT(STOP_COUNT)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(head_cmd), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_out_byte(out_out_byte),
    .out_kind(out_kind), .out_status(out_status), .out_truncated(out_truncated),
    .out_last(out_last)
  );
endmodule

/* dv/tb_stopword_filter_unit.sv */
// Self-checking testbench of the stopword filter: directed and random text and table traffic
`timescale 1ns / 1ps
module tb_stopword_filter_unit;
  localparam int WORD_LIMIT  = sfu_pkg::WORD_MAX_DEF;
  localparam int ENTRY_LIMIT = sfu_pkg::STOP_LEN_DEF;
  localparam int TABLE_SIZE  = sfu_pkg::STOP_COUNT_DEF;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [7:0] ch;
    logic       kind;
    logic [1:0] status;
    logic       trunc;
    logic       last;
  } filter_out_t;

  // Predict the filtered stream and hold expected outputs in arrival order.
  class filter_predictor;
    logic [7:0]  word_buf[WORD_LIMIT];
    int          word_len;
    bit          word_ovf;
    bit          line_start;
    logic [7:0]  stop_chars[TABLE_SIZE][ENTRY_LIMIT];
    int          stop_len[TABLE_SIZE];
    int          stop_cnt;
    int          load_len;
    bit          load_ovf;
    filter_out_t pending_out[$];
    int          mismatches;
    int          outs_checked;

    function void clear_state();
      word_len   = 0;
      word_ovf   = 0;
      line_start = 1;
      stop_cnt   = 0;
      load_len   = 0;
      load_ovf   = 0;
      pending_out.delete();
      mismatches   = 0;
      outs_checked = 0;
    endfunction

    function bit is_stop();
      bit same;
      if (word_ovf || word_len == 0) return 0;
      for (int e = 0; e < stop_cnt; e++) begin
        if (stop_len[e] == word_len) begin
          same = 1;
          for (int i = 0; i < word_len; i++)
            if (stop_chars[e][i] != word_buf[i]) same = 0;
          if (same) return 1;
        end
      end
      return 0;
    endfunction

    // Work out the outputs that one accepted item causes.
    function void take_item(logic [1:0] act, logic [7:0] b);
      bit          delim;
      logic [1:0]  st;
      filter_out_t run[$];
      filter_out_t r;
      delim = (b == sfu_pkg::CH_SPACE) || (b == sfu_pkg::CH_NEWLINE);
      st = sfu_pkg::ST_OK;
      case (act)
        sfu_pkg::ACT_TEXT: begin
          if (!delim) begin
            if (word_len < WORD_LIMIT) begin
              word_buf[word_len] = b;
              word_len++;
            end else begin
              word_ovf = 1;
            end
          end else begin
            if (!is_stop()) begin
              if (!line_start)
                run.push_back({sfu_pkg::CH_SPACE, sfu_pkg::KIND_TEXT, sfu_pkg::ST_OK,
                               word_ovf, 1'b0});
              for (int i = 0; i < word_len; i++)
                run.push_back({word_buf[i], sfu_pkg::KIND_TEXT, sfu_pkg::ST_OK,
                               word_ovf, 1'b0});
              line_start = 0;
            end
            if (b == sfu_pkg::CH_NEWLINE) begin
              run.push_back({sfu_pkg::CH_NEWLINE, sfu_pkg::KIND_TEXT, sfu_pkg::ST_OK,
                             word_ovf, 1'b0});
              line_start = 1;
            end
            word_len = 0;
            word_ovf = 0;
          end
        end
        sfu_pkg::ACT_LOAD: begin
          if (!delim) begin
            if (load_len < ENTRY_LIMIT) begin
              if (stop_cnt < TABLE_SIZE) stop_chars[stop_cnt][load_len] = b;
              load_len++;
            end else begin
              load_ovf = 1;
            end
          end else begin
            if (load_ovf) begin
              st = sfu_pkg::ST_LONG;
            end else if (load_len != 0) begin
              if (stop_cnt >= TABLE_SIZE) begin
                st = sfu_pkg::ST_FULL;
              end else begin
                stop_len[stop_cnt] = load_len;
                stop_cnt++;
              end
            end
            load_len = 0;
            load_ovf = 0;
          end
          run.push_back({8'd0, sfu_pkg::KIND_STATUS, st, 1'b0, 1'b0});
        end
        sfu_pkg::ACT_CLEAR: begin
          stop_cnt = 0;
          load_len = 0;
          load_ovf = 0;
          run.push_back({8'd0, sfu_pkg::KIND_STATUS, sfu_pkg::ST_OK, 1'b0, 1'b0});
        end
        default: ;
      endcase
      if (run.size() > 0) begin
        r = run.pop_back();
        r.last = 1'b1;
        run.push_back(r);
      end
      foreach (run[i]) pending_out.push_back(run[i]);
    endfunction

    // Compare one accepted output with the oldest expectation.
    function void check_out(filter_out_t got);
      filter_out_t want;
      outs_checked++;
      if (pending_out.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output: %p", got);
        return;
      end
      want = pending_out.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at output %0d: expected %p, got %p", outs_checked, want, got);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_action = sfu_pkg::ACT_TEXT;
  logic [7:0] in_byte_value = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_out_byte;
  logic       out_kind;
  logic [1:0] out_status;
  logic       out_truncated;
  logic       out_last;

  filter_predictor pred = new();
  int send_idle_pct = 8;
  int recv_idle_pct = 60;
  int hold_cycles   = 0;
  int cycle_count   = 0;
  int items_sent    = 0;

  stopword_filter_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_action(in_action), .in_byte_value(in_byte_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_out_byte(out_out_byte), .out_kind(out_kind), .out_status(out_status),
    .out_truncated(out_truncated), .out_last(out_last)
  );

  always #4 clk = ~clk;

  // Receiver: stall at random, or hold off for a long stretch when asked.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Check every output item taken at a rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      pred.check_out({out_out_byte, out_kind, out_status, out_truncated, out_last});
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offer one item, idle first at random, and hold it until taken.
  task automatic send_item(logic [1:0] act, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_byte_value <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred.take_item(act, b);
    items_sent++;
    @(negedge clk);
  endtask

  // Send a word of given length from a small alphabet, then a delimiter.
  task automatic send_word(logic [1:0] act, int len, logic [7:0] delim);
    for (int i = 0; i < len; i++) send_item(act, 8'(8'h61 + $urandom_range(2)));
    send_item(act, delim);
  endtask

  function automatic logic [7:0] pick_delim();
    return ($urandom_range(3) == 0) ? sfu_pkg::CH_NEWLINE : sfu_pkg::CH_SPACE;
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == sfu_pkg::CH_SPACE || b == sfu_pkg::CH_NEWLINE) b = 8'h7a;
    return b;
  endfunction

  initial begin
    int pick;
    pred.clear_state();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: clear, the unused action, a stopword, an empty load, an overlong load.
    send_item(sfu_pkg::ACT_CLEAR, 8'd0);
    send_item(sfu_pkg::ACT_UNUSED, 8'hff);
    send_item(sfu_pkg::ACT_LOAD, 8'h61);
    send_item(sfu_pkg::ACT_LOAD, 8'h62);
    send_item(sfu_pkg::ACT_LOAD, sfu_pkg::CH_SPACE);
    send_item(sfu_pkg::ACT_LOAD, sfu_pkg::CH_NEWLINE);
    for (int i = 0; i < ENTRY_LIMIT + 1; i++) send_item(sfu_pkg::ACT_LOAD, 8'h63);
    send_item(sfu_pkg::ACT_LOAD, sfu_pkg::CH_SPACE);
    // Text: stopword at line start, empty words, extreme bytes, then a newline.
    send_item(sfu_pkg::ACT_TEXT, 8'h61);
    send_item(sfu_pkg::ACT_TEXT, 8'h62);
    send_item(sfu_pkg::ACT_TEXT, sfu_pkg::CH_SPACE);
    send_item(sfu_pkg::ACT_TEXT, sfu_pkg::CH_SPACE);
    send_item(sfu_pkg::ACT_TEXT, 8'h00);
    send_item(sfu_pkg::ACT_TEXT, 8'hff);
    send_item(sfu_pkg::ACT_TEXT, sfu_pkg::CH_SPACE);
    send_item(sfu_pkg::ACT_TEXT, 8'h61);
    send_item(sfu_pkg::ACT_TEXT, 8'h62);
    send_item(sfu_pkg::ACT_TEXT, sfu_pkg::CH_NEWLINE);
    send_item(sfu_pkg::ACT_TEXT, sfu_pkg::CH_NEWLINE);
    // Overlong word: truncated on every character of its run.
    for (int i = 0; i < WORD_LIMIT + 5; i++) send_item(sfu_pkg::ACT_TEXT, plain_byte());
    send_item(sfu_pkg::ACT_TEXT, sfu_pkg::CH_NEWLINE);

    // Swap the idling, and hold off the receiver while items keep coming.
    send_idle_pct = 60;
    recv_idle_pct = 8;
    hold_cycles   = 400;
    for (int i = 0; i < 5; i++)
      send_word(sfu_pkg::ACT_TEXT, 1 + $urandom_range(4), pick_delim());

    // Random traffic: mostly well-formed words and loads, some noise.
    for (int n = 0; n < 40; ) begin
      if (n >= 20) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      pick = $urandom_range(99);
      if (pick < 55) begin
        pick = $urandom_range(5);
        send_word(sfu_pkg::ACT_TEXT, pick, pick_delim());
        n += pick + 1;
      end else if (pick < 75) begin
        pick = 1 + $urandom_range(3);
        send_word(sfu_pkg::ACT_LOAD, pick, pick_delim());
        n += pick + 1;
      end else if (pick < 80) begin
        send_item(sfu_pkg::ACT_CLEAR, 8'($urandom_range(255)));
        n++;
      end else if (pick < 85) begin
        send_item(sfu_pkg::ACT_UNUSED, 8'($urandom_range(255)));
        n++;
      end else begin
        send_item(2'($urandom_range(1)), 8'($urandom_range(255)));
        n++;
      end
    end
    in_valid <= 1'b0;

    // Drain, then let trailing work settle.
    while (pred.pending_out.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d items (text, loads, overlong words and entries, clears, a long hold),",
             items_sent);
    $display("checked %0d outputs with %0d mismatches.", pred.outs_checked, pred.mismatches);
    if (pred.mismatches == 0 && pred.pending_out.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
